// ===== hw/rtl/mmtb_pkg.sv =====
// ----------------------------------------------------------------------------
// mmtb_pkg
// Shared types, codes and defaults of the multi-mode timer bank.
// ----------------------------------------------------------------------------
package mmtb_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;
    localparam int FRAC_BITS      = 16;

    localparam logic [3:0] OP_TICK       = 4'd0;
    localparam logic [3:0] OP_CREATE     = 4'd1;
    localparam logic [3:0] OP_PAUSE      = 4'd2;
    localparam logic [3:0] OP_RESUME     = 4'd3;
    localparam logic [3:0] OP_CLEAR      = 4'd4;
    localparam logic [3:0] OP_RESTART    = 4'd5;
    localparam logic [3:0] OP_PAUSE_ALL  = 4'd6;
    localparam logic [3:0] OP_RESUME_ALL = 4'd7;
    localparam logic [3:0] OP_CLEAR_ALL  = 4'd8;
    localparam logic [3:0] OP_QUERY      = 4'd9;

    localparam logic [2:0] KIND_PROGRESS   = 3'd0;
    localparam logic [2:0] KIND_COMPLETION = 3'd1;
    localparam logic [2:0] KIND_ACK        = 3'd2;
    localparam logic [2:0] KIND_QUERY      = 3'd3;
    localparam logic [2:0] KIND_END        = 3'd4;

    localparam logic [1:0] MODE_ONESHOT  = 2'd0;
    localparam logic [1:0] MODE_INTERVAL = 2'd1;
    localparam logic [1:0] MODE_COUNTED  = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ZERO_DUR = 2'd1;
    localparam logic [1:0] STAT_IN_USE   = 2'd2;

    typedef struct packed {
        logic       load;
        logic       rd_cmd;
        logic       rd_walk;
        logic       exec;
        logic       p1_eval;
        logic       fin;
        logic       p2_eval;
        logic       walk_clr;
        logic       walk_inc;
        logic       div_start;
        logic       emit;
        logic [2:0] emit_kind;
    } ctl_t;

    typedef struct packed {
        logic is_tick;
        logic is_query;
        logic running;
        logic q_div;
        logic ev_live;
        logic ev_pen;
        logic ev_done;
        logic ev_div;
        logic w_done;
        logic div_busy;
        logic out_free;
        logic walk_last;
    } sts_t;

endpackage

// ===== hw/rtl/mmtb_div.sv =====
// ----------------------------------------------------------------------------
// mmtb_div
// Restoring divider, one quotient bit per cycle, for the progress fraction.
// ----------------------------------------------------------------------------
module mmtb_div #(
    parameter int TIME_BITS = mmtb_pkg::TIME_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [TIME_BITS-1:0]             num,
    input  logic [TIME_BITS-1:0]             den,
    output logic                             busy,
    output logic [mmtb_pkg::FRAC_BITS-1:0]   quo
);

    localparam int QB = mmtb_pkg::FRAC_BITS;
    localparam int CB = $clog2(QB);

    logic [TIME_BITS:0]   rem_reg;
    logic [TIME_BITS-1:0] den_reg;
    logic [QB-1:0]        quo_reg;
    logic [CB-1:0]        cnt_reg;
    logic                 busy_reg;
    logic [TIME_BITS:0]   shifted;
    logic                 ge;

    assign shifted = {rem_reg[TIME_BITS-1:0], 1'b0};
    assign ge      = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CB'(QB - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? shifted - {1'b0, den_reg} : shifted;
            quo_reg <= {quo_reg[QB-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

// ===== hw/rtl/mmtb_dp.sv =====
// ----------------------------------------------------------------------------
// mmtb_dp
// Timer storage, tick arithmetic, command updates and the result register.
// ----------------------------------------------------------------------------
module mmtb_dp #(
    parameter int NUM_TIMERS = mmtb_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = mmtb_pkg::TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mmtb_pkg::ctl_t       ctl,
    output mmtb_pkg::sts_t       sts,
    input  logic [3:0]           s_operation,
    input  logic [3:0]           s_slot,
    input  logic [1:0]           s_mode,
    input  logic [31:0]          s_duration,
    input  logic [15:0]          s_loop_count,
    input  logic                 s_progress_enable,
    input  logic [31:0]          s_delta,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [2:0]           m_kind,
    output logic [3:0]           m_slot_out,
    output logic [1:0]           m_status,
    output logic [16:0]          m_progress,
    output logic [31:0]          m_remaining,
    output logic                 m_exists,
    output logic                 m_is_active,
    output logic [4:0]           m_active_count,
    output logic                 m_running,
    output logic                 m_last
);

    localparam int IW = $clog2(NUM_TIMERS);
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int TB = TIME_BITS;
    localparam int SW = ((TB > 32) ? TB : 32) + 1;
    localparam logic [SW-1:0] TMAX_W = {{(SW-TB){1'b0}}, {TB{1'b1}}};
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    logic [3:0]  in_op_reg;
    logic [3:0]  in_slot_reg;
    logic [1:0]  in_mode_reg;
    logic [31:0] in_dur_reg;
    logic [15:0] in_loops_reg;
    logic        in_pen_reg;
    logic [31:0] in_delta_reg;

    logic [1:0]    mode_mem [NUM_TIMERS];
    logic [TB-1:0] per_mem  [NUM_TIMERS];
    logic [TB-1:0] el_mem   [NUM_TIMERS];
    logic [15:0]   tgt_mem  [NUM_TIMERS];
    logic [15:0]   lps_mem  [NUM_TIMERS];
    logic          pen_mem  [NUM_TIMERS];

    logic [1:0]    rd_mode_reg;
    logic [TB-1:0] rd_per_reg;
    logic [TB-1:0] rd_el_reg;
    logic [15:0]   rd_tgt_reg;
    logic [15:0]   rd_lps_reg;
    logic          rd_pen_reg;

    logic [NUM_TIMERS-1:0] occ_reg;
    logic [NUM_TIMERS-1:0] act_reg;
    logic                  running_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         freed_reg;
    logic [CW-1:0]         final_cnt_reg;
    logic                  final_run_reg;
    logic [IW-1:0]         walk_reg;

    logic [TB-1:0] w_el_reg;
    logic [TB-1:0] w_per_reg;
    logic          w_done_reg;
    logic          w_ex_reg;
    logic          w_act_reg;
    logic [1:0]    st_reg;

    logic [IW-1:0] cidx;
    logic          cvalid;
    logic          c_occ;
    logic [IW-1:0] ridx;
    logic [SW-1:0] sum_w;
    logic [TB-1:0] e_new;
    logic          ev_done;
    logic          ev_live;
    logic [15:0]   lsat;
    logic          ev_free;
    logic [SW-1:0] dur_w;
    logic [TB-1:0] per_c;
    logic          q_ex;
    logic          div_busy;
    logic [15:0]   div_quo;
    logic [TB-1:0] div_num;
    logic [CW-1:0] fin_cnt;
    logic          run_eff;
    logic [16:0]   pcalc;
    logic [31:0]   rcalc;
    logic          out_free;

    logic          m_valid_reg;
    logic [2:0]    m_kind_reg;
    logic [3:0]    m_slot_reg;
    logic [1:0]    m_status_reg;
    logic [16:0]   m_prog_reg;
    logic [31:0]   m_rem_reg;
    logic          m_ex_reg;
    logic          m_act_reg;
    logic [4:0]    m_cnt_reg;
    logic          m_run_reg;
    logic          m_last_reg;

    assign cidx    = IW'(in_slot_reg);
    assign cvalid  = {28'd0, in_slot_reg} < 32'(NUM_TIMERS);
    assign c_occ   = cvalid ? occ_reg[cidx] : 1'b0;
    assign ridx    = ctl.rd_walk ? walk_reg : cidx;
    assign q_ex    = c_occ;

    assign sum_w   = SW'(rd_el_reg) + SW'(in_delta_reg);
    assign e_new   = (sum_w > TMAX_W) ? TB'(TMAX_W) : TB'(sum_w);
    assign ev_done = e_new >= rd_per_reg;
    assign ev_live = occ_reg[walk_reg] & act_reg[walk_reg];
    assign lsat    = (rd_lps_reg == 16'hFFFF) ? rd_lps_reg : rd_lps_reg + 16'd1;
    assign ev_free = ev_done && (rd_mode_reg != mmtb_pkg::MODE_INTERVAL) &&
                     ((rd_mode_reg != mmtb_pkg::MODE_COUNTED) ||
                      ((rd_tgt_reg != 16'd0) && (lsat >= rd_tgt_reg)));

    assign dur_w   = SW'(in_dur_reg);
    assign per_c   = (dur_w > TMAX_W) ? TB'(TMAX_W) : TB'(dur_w);
    assign div_num = ctl.exec ? rd_el_reg : e_new;
    assign fin_cnt = count_reg - freed_reg;
    assign run_eff = (in_op_reg == mmtb_pkg::OP_CLEAR && count_reg == '0) ? 1'b0
                                                                            : running_reg;
    assign pcalc   = (w_el_reg >= w_per_reg) ? ONE_Q16 : {1'b0, div_quo};
    assign rcalc   = (w_per_reg > w_el_reg) ? 32'(w_per_reg - w_el_reg) : 32'd0;
    assign out_free = !m_valid_reg || m_ready;

    mmtb_div #(
        .TIME_BITS(TIME_BITS)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (ctl.div_start),
        .num    (div_num),
        .den    (rd_per_reg),
        .busy   (div_busy),
        .quo    (div_quo)
    );

    always_comb begin
        count_next = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            count_next = count_next + CW'(occ_reg[i] & act_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            in_op_reg    <= s_operation;
            in_slot_reg  <= s_slot;
            in_mode_reg  <= s_mode;
            in_dur_reg   <= s_duration;
            in_loops_reg <= s_loop_count;
            in_pen_reg   <= s_progress_enable;
            in_delta_reg <= s_delta;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_cmd || ctl.rd_walk) begin
            rd_mode_reg <= mode_mem[ridx];
            rd_per_reg  <= per_mem[ridx];
            rd_el_reg   <= el_mem[ridx];
            rd_tgt_reg  <= tgt_mem[ridx];
            rd_lps_reg  <= lps_mem[ridx];
            rd_pen_reg  <= pen_mem[ridx];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.exec && cvalid) begin
            if (in_op_reg == mmtb_pkg::OP_CREATE && in_dur_reg != 32'd0 && !c_occ) begin
                mode_mem[cidx] <= (in_mode_reg == mmtb_pkg::MODE_UNUSED)
                                  ? mmtb_pkg::MODE_ONESHOT : in_mode_reg;
                per_mem[cidx]  <= per_c;
                el_mem[cidx]   <= '0;
                tgt_mem[cidx]  <= in_loops_reg;
                lps_mem[cidx]  <= 16'd0;
                pen_mem[cidx]  <= in_pen_reg;
            end else if (in_op_reg == mmtb_pkg::OP_RESTART && c_occ) begin
                el_mem[cidx]  <= '0;
                lps_mem[cidx] <= 16'd0;
            end
        end else if (ctl.p2_eval && ev_live) begin
            if (!ev_done) begin
                el_mem[walk_reg] <= e_new;
            end else if (rd_mode_reg == mmtb_pkg::MODE_INTERVAL) begin
                el_mem[walk_reg] <= '0;
            end else if (rd_mode_reg == mmtb_pkg::MODE_COUNTED) begin
                lps_mem[walk_reg] <= lsat;
                el_mem[walk_reg]  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            act_reg     <= '0;
            running_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            count_reg <= count_next;
            if (ctl.exec) begin
                unique case (in_op_reg) inside
                    mmtb_pkg::OP_CREATE: begin
                        if (in_dur_reg != 32'd0 && cvalid && !c_occ) begin
                            occ_reg[cidx] <= 1'b1;
                            act_reg[cidx] <= 1'b1;
                            running_reg   <= 1'b1;
                        end
                    end
                    mmtb_pkg::OP_PAUSE, mmtb_pkg::OP_RESUME: begin
                        if (c_occ) begin
                            act_reg[cidx] <= (in_op_reg == mmtb_pkg::OP_RESUME);
                        end
                    end
                    mmtb_pkg::OP_CLEAR: begin
                        if (cvalid) begin
                            occ_reg[cidx] <= 1'b0;
                            act_reg[cidx] <= 1'b0;
                        end
                    end
                    mmtb_pkg::OP_RESTART: begin
                        if (c_occ) begin
                            act_reg[cidx] <= 1'b1;
                        end
                    end
                    mmtb_pkg::OP_PAUSE_ALL, mmtb_pkg::OP_RESUME_ALL: begin
                        for (int i = 0; i < NUM_TIMERS; i++) begin
                            if (occ_reg[i]) begin
                                act_reg[i] <= (in_op_reg == mmtb_pkg::OP_RESUME_ALL);
                            end
                        end
                    end
                    mmtb_pkg::OP_CLEAR_ALL: begin
                        occ_reg     <= '0;
                        act_reg     <= '0;
                        running_reg <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end else if (ctl.p2_eval && ev_live && ev_free) begin
                occ_reg[walk_reg] <= 1'b0;
                act_reg[walk_reg] <= 1'b0;
            end
            if (ctl.emit) begin
                if (ctl.emit_kind == mmtb_pkg::KIND_END) begin
                    running_reg <= final_run_reg;
                end else if (ctl.emit_kind == mmtb_pkg::KIND_ACK ||
                             ctl.emit_kind == mmtb_pkg::KIND_QUERY) begin
                    running_reg <= run_eff;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg  <= '0;
            freed_reg <= '0;
        end else begin
            if (ctl.walk_clr) begin
                walk_reg <= '0;
            end else if (ctl.walk_inc) begin
                walk_reg <= walk_reg + 1'b1;
            end
            if (ctl.load) begin
                freed_reg <= '0;
            end else if (ctl.p1_eval && ev_live && ev_free) begin
                freed_reg <= freed_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.fin) begin
            final_cnt_reg <= fin_cnt;
            final_run_reg <= running_reg && (fin_cnt != '0);
        end
        if (ctl.exec) begin
            w_el_reg  <= rd_el_reg;
            w_per_reg <= rd_per_reg;
            w_ex_reg  <= q_ex;
            w_act_reg <= q_ex && act_reg[cidx];
            st_reg    <= mmtb_pkg::STAT_OK;
            if (in_op_reg == mmtb_pkg::OP_CREATE) begin
                if (in_dur_reg == 32'd0) begin
                    st_reg <= mmtb_pkg::STAT_ZERO_DUR;
                end else if (!cvalid || c_occ) begin
                    st_reg <= mmtb_pkg::STAT_IN_USE;
                end
            end
        end else if (ctl.p2_eval) begin
            w_el_reg   <= e_new;
            w_per_reg  <= rd_per_reg;
            w_done_reg <= ev_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            m_kind_reg   <= ctl.emit_kind;
            m_slot_reg   <= in_slot_reg;
            m_status_reg <= mmtb_pkg::STAT_OK;
            m_prog_reg   <= 17'd0;
            m_rem_reg    <= 32'd0;
            m_ex_reg     <= 1'b0;
            m_act_reg    <= 1'b0;
            m_cnt_reg    <= 5'(final_cnt_reg);
            m_run_reg    <= final_run_reg;
            m_last_reg   <= 1'b1;
            case (ctl.emit_kind) inside
                mmtb_pkg::KIND_PROGRESS, mmtb_pkg::KIND_COMPLETION: begin
                    m_slot_reg <= 4'(walk_reg);
                    m_prog_reg <= pcalc;
                    m_rem_reg  <= rcalc;
                    m_last_reg <= 1'b0;
                end
                mmtb_pkg::KIND_QUERY: begin
                    m_prog_reg <= w_ex_reg ? pcalc : 17'd0;
                    m_rem_reg  <= w_ex_reg ? rcalc : 32'd0;
                    m_ex_reg   <= w_ex_reg;
                    m_act_reg  <= w_act_reg;
                    m_cnt_reg  <= 5'(count_reg);
                    m_run_reg  <= run_eff;
                end
                mmtb_pkg::KIND_ACK: begin
                    m_status_reg <= st_reg;
                    m_cnt_reg    <= 5'(count_reg);
                    m_run_reg    <= run_eff;
                end
                default: begin
                    m_slot_reg <= 4'd0;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_slot_out     = m_slot_reg;
    assign m_status       = m_status_reg;
    assign m_progress     = m_prog_reg;
    assign m_remaining    = m_rem_reg;
    assign m_exists       = m_ex_reg;
    assign m_is_active    = m_act_reg;
    assign m_active_count = m_cnt_reg;
    assign m_running      = m_run_reg;
    assign m_last         = m_last_reg;

    always_comb begin
        sts.is_tick   = in_op_reg == mmtb_pkg::OP_TICK;
        sts.is_query  = in_op_reg == mmtb_pkg::OP_QUERY;
        sts.running   = running_reg;
        sts.q_div     = q_ex && (rd_el_reg < rd_per_reg);
        sts.ev_live   = ev_live;
        sts.ev_pen    = rd_pen_reg;
        sts.ev_done   = ev_done;
        sts.ev_div    = rd_pen_reg && !ev_done;
        sts.w_done    = w_done_reg;
        sts.div_busy  = div_busy;
        sts.out_free  = out_free;
        sts.walk_last = walk_reg == IW'(NUM_TIMERS - 1);
    end

endmodule

// ===== hw/rtl/mmtb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmtb_ctrl
// Sequencer for commands, queries and the two-pass tick walk.
// ----------------------------------------------------------------------------
module mmtb_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mmtb_pkg::sts_t sts,
    output mmtb_pkg::ctl_t ctl
);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_RD     = 15'b000000000000010,
        S_EXEC   = 15'b000000000000100,
        S_DIV    = 15'b000000000001000,
        S_CNT    = 15'b000000000010000,
        S_EMIT   = 15'b000000000100000,
        S_T1RD   = 15'b000000001000000,
        S_T1EV   = 15'b000000010000000,
        S_TFIN   = 15'b000000100000000,
        S_T2RD   = 15'b000001000000000,
        S_T2EV   = 15'b000010000000000,
        S_T2DIV  = 15'b000100000000000,
        S_T2PRG  = 15'b001000000000000,
        S_T2CMP  = 15'b010000000000000,
        S_TEND   = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = state_reg == S_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                if (sts.is_tick) begin
                    ctl.walk_clr = 1'b1;
                    state_next   = sts.running ? S_T1RD : S_TFIN;
                end else begin
                    ctl.rd_cmd = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                ctl.exec = 1'b1;
                if (sts.is_query && sts.q_div) begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    state_next = S_CNT;
                end
            end
            S_DIV: begin
                if (!sts.div_busy) begin
                    state_next = S_CNT;
                end
            end
            S_CNT: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = sts.is_query ? mmtb_pkg::KIND_QUERY : mmtb_pkg::KIND_ACK;
                    state_next    = S_IDLE;
                end
            end
            S_T1RD: begin
                ctl.rd_walk = 1'b1;
                state_next  = S_T1EV;
            end
            S_T1EV: begin
                ctl.p1_eval = 1'b1;
                if (sts.walk_last) begin
                    state_next = S_TFIN;
                end else begin
                    ctl.walk_inc = 1'b1;
                    state_next   = S_T1RD;
                end
            end
            S_TFIN: begin
                ctl.fin = 1'b1;
                if (sts.running) begin
                    ctl.walk_clr = 1'b1;
                    state_next   = S_T2RD;
                end else begin
                    state_next = S_TEND;
                end
            end
            S_T2RD: begin
                ctl.rd_walk = 1'b1;
                state_next  = S_T2EV;
            end
            S_T2EV: begin
                ctl.p2_eval = 1'b1;
                if (sts.ev_live && sts.ev_div) begin
                    ctl.div_start = 1'b1;
                    state_next    = S_T2DIV;
                end else if (sts.ev_live && sts.ev_pen) begin
                    state_next = S_T2PRG;
                end else if (sts.ev_live && sts.ev_done) begin
                    state_next = S_T2CMP;
                end else if (sts.walk_last) begin
                    state_next = S_TEND;
                end else begin
                    ctl.walk_inc = 1'b1;
                    state_next   = S_T2RD;
                end
            end
            S_T2DIV: begin
                if (!sts.div_busy) begin
                    state_next = S_T2PRG;
                end
            end
            S_T2PRG: begin
                if (sts.out_free) begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = mmtb_pkg::KIND_PROGRESS;
                    if (sts.w_done) begin
                        state_next = S_T2CMP;
                    end else if (sts.walk_last) begin
                        state_next = S_TEND;
                    end else begin
                        ctl.walk_inc = 1'b1;
                        state_next   = S_T2RD;
                    end
                end
            end
            S_T2CMP: begin
                if (sts.out_free) begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = mmtb_pkg::KIND_COMPLETION;
                    if (sts.walk_last) begin
                        state_next = S_TEND;
                    end else begin
                        ctl.walk_inc = 1'b1;
                        state_next   = S_T2RD;
                    end
                end
            end
            S_TEND: begin
                if (sts.out_free) begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = mmtb_pkg::KIND_END;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/multi_mode_timer_bank.sv =====
// ----------------------------------------------------------------------------
// multi_mode_timer_bank
// Bank of numbered one-shot, interval and counted-repeat timers.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one command word per handshake: tick, create,
//   pause, resume, clear, restart, pause/resume/clear all, or query.
//   The m_ channel returns result words; m_last marks the final word of
//   each input word. Commands and queries give exactly one word; a tick
//   gives optional progress and completion words per active slot and
//   always ends with an end-of-tick word.
//   A query of an existing slot that has not yet expired waits for the
//   progress divider.
//   A tick on a running bank makes two walks over the slot store (one read
//   port, registered) and runs the progress divider for each progress
//   word below one.
//   s_ready is high only between items; the next word is taken while the
//   last result still waits in the output register.
//   Reset clears all slots and stops the bank. When the receiver stalls,
//   the walk holds at the pending word until m_ready returns.
// ----------------------------------------------------------------------------
module multi_mode_timer_bank #(
    parameter int NUM_TIMERS = mmtb_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = mmtb_pkg::TIME_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_operation,
    input  logic [3:0]  s_slot,
    input  logic [1:0]  s_mode,
    input  logic [31:0] s_duration,
    input  logic [15:0] s_loop_count,
    input  logic        s_progress_enable,
    input  logic [31:0] s_delta,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [3:0]  m_slot_out,
    output logic [1:0]  m_status,
    output logic [16:0] m_progress,
    output logic [31:0] m_remaining,
    output logic        m_exists,
    output logic        m_is_active,
    output logic [4:0]  m_active_count,
    output logic        m_running,
    output logic        m_last
);

    mmtb_pkg::ctl_t ctl;
    mmtb_pkg::sts_t sts;

    mmtb_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .ctl    (ctl)
    );

    mmtb_dp #(
        .NUM_TIMERS(NUM_TIMERS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctl              (ctl),
        .sts              (sts),
        .s_operation      (s_operation),
        .s_slot           (s_slot),
        .s_mode           (s_mode),
        .s_duration       (s_duration),
        .s_loop_count     (s_loop_count),
        .s_progress_enable(s_progress_enable),
        .s_delta          (s_delta),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_kind           (m_kind),
        .m_slot_out       (m_slot_out),
        .m_status         (m_status),
        .m_progress       (m_progress),
        .m_remaining      (m_remaining),
        .m_exists         (m_exists),
        .m_is_active      (m_is_active),
        .m_active_count   (m_active_count),
        .m_running        (m_running),
        .m_last           (m_last)
    );

endmodule

// ===== hw/rtl/mmtb_checker.sv =====
// ----------------------------------------------------------------------------
// mmtb_checker
// Port-level checks of the timer bank result stream.
// ----------------------------------------------------------------------------
module mmtb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_kind,
    input logic [16:0] m_progress,
    input logic [31:0] m_remaining,
    input logic        m_exists,
    input logic        m_is_active,
    input logic [4:0]  m_active_count,
    input logic        m_running,
    input logic        m_last
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_last)
            && $stable(m_remaining) && $stable(m_progress))
        else $error("result word changed while stalled");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == mmtb_pkg::KIND_END |-> m_last)
        else $error("end of tick not marked last");

    a_event_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == mmtb_pkg::KIND_PROGRESS ||
                    m_kind == mmtb_pkg::KIND_COMPLETION) |-> !m_last)
        else $error("tick event marked last");

    a_query_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != mmtb_pkg::KIND_QUERY |-> !m_exists && !m_is_active)
        else $error("query flags outside query answer");

    a_stop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == mmtb_pkg::KIND_END && m_active_count == 5'd0
            |-> !m_running)
        else $error("bank still running after tick with no active timer");

endmodule

bind multi_mode_timer_bank mmtb_checker u_mmtb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_kind        (m_kind),
    .m_progress    (m_progress),
    .m_remaining   (m_remaining),
    .m_exists      (m_exists),
    .m_is_active   (m_is_active),
    .m_active_count(m_active_count),
    .m_running     (m_running),
    .m_last        (m_last)
);
